>>> rtl/core/sdq_pkg.sv
// Shared types, constants and helpers for the sorted deadline queue.
package sdq_pkg;

    localparam int DEPTH   = 16;
    localparam int AW      = $clog2(DEPTH);
    localparam int CW      = $clog2(DEPTH + 1);
    localparam int DUE_W   = 32;
    localparam int TAG_W   = 8;
    localparam int OCC_W   = 5;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_TICK   = 1'b1;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_INSERT = 2'd1,
        EV_DROP   = 2'd2,
        EV_FIRE   = 2'd3
    } ev_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_ICMP,
        ST_PLACE,
        ST_TCMP,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [DUE_W-1:0] due;
        logic [TAG_W-1:0] tag;
    } entry_t;

    typedef struct packed {
        logic          we;
        logic [AW-1:0] waddr;
        entry_t        wdata;
        logic [AW-1:0] raddr;
    } store_req_t;

    typedef struct packed {
        ev_t              ev;
        logic [TAG_W-1:0] tag;
        logic [DUE_W-1:0] due;
        logic [OCC_W-1:0] occ;
    } result_t;

    // Physical slot of logical position pos in the ring that starts at head.
    function automatic logic [AW-1:0] wrap_addr(input logic [AW-1:0] head,
                                                input logic [CW-1:0] pos);
        logic [CW:0] sum;
        sum = (CW+1)'(head) + (CW+1)'(pos);
        if (sum >= (CW+1)'(DEPTH)) begin
            sum = sum - (CW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

endpackage

>>> rtl/core/sorted_deadline_queue_top.sv
// Top level of the sorted deadline queue: sequencer, entry memory, result register.
//
//   channel   dir   handshake           payload
//   s_*       in    s_valid / s_ready   s_action, s_due_time, s_job_tag, s_now_time
//   m_*       out   m_valid / m_ready   m_event_res, m_fired_tag, m_fired_due, m_occupancy
//
// Insert: the walk starts at the tail and moves each entry with a later deadline up one
//   slot, then places the job. The walk reads one entry per cycle, one read port.
// Tick: front read, one compare. Dropped insert or empty tick: no walk, no compare.
// aresetn (sync, active low) empties the queue; memory contents are not cleared.
// s_ready is high only while idle; a held result beat does not block the next accept,
//   but the following result waits in the sequencer until m_ready frees the register.
module sorted_deadline_queue_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_action,
    input  logic [sdq_pkg::DUE_W-1:0]         s_due_time,
    input  logic [sdq_pkg::TAG_W-1:0]         s_job_tag,
    input  logic [sdq_pkg::DUE_W-1:0]         s_now_time,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [1:0]                        m_event_res,
    output logic [sdq_pkg::TAG_W-1:0]         m_fired_tag,
    output logic [sdq_pkg::DUE_W-1:0]         m_fired_due,
    output logic [sdq_pkg::OCC_W-1:0]         m_occupancy
);

    sdq_pkg::store_req_t st_req;
    sdq_pkg::entry_t     rd_data;
    sdq_pkg::result_t    res;
    logic                res_valid;
    logic                res_ready;

    // output beat register
    logic                m_valid_reg, m_valid_next;
    sdq_pkg::result_t    m_res_reg, m_res_next;

    sdq_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_action   (s_action),
        .s_due_time (s_due_time),
        .s_job_tag  (s_job_tag),
        .s_now_time (s_now_time),
        .st_req     (st_req),
        .rd_data    (rd_data),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    sdq_store u_store (
        .aclk    (aclk),
        .req     (st_req),
        .rd_data (rd_data)
    );

    // register is free when empty or being drained this cycle
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (res_ready) begin
            m_valid_next = res_valid;
            if (res_valid) begin
                m_res_next = res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_res_reg <= m_res_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_event_res = m_res_reg.ev;
    assign m_fired_tag = m_res_reg.tag;
    assign m_fired_due = m_res_reg.due;
    assign m_occupancy = m_res_reg.occ;

endmodule

>>> rtl/core/sdq_store.sv
// Entry memory: one write port, one read port, registered read data.
module sdq_store (
    input  logic               aclk,
    input  sdq_pkg::store_req_t req,
    output sdq_pkg::entry_t     rd_data
);

    sdq_pkg::entry_t mem [sdq_pkg::DEPTH];
    sdq_pkg::entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        rd_data_reg <= mem[req.raddr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/sdq_seq.sv
// Sequencer: walks the ring with one shared comparator for inserts and ticks.
module sdq_seq (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_action,
    input  logic [sdq_pkg::DUE_W-1:0]         s_due_time,
    input  logic [sdq_pkg::TAG_W-1:0]         s_job_tag,
    input  logic [sdq_pkg::DUE_W-1:0]         s_now_time,
    output sdq_pkg::store_req_t               st_req,
    input  sdq_pkg::entry_t                   rd_data,
    output logic                              res_valid,
    input  logic                              res_ready,
    output sdq_pkg::result_t                  res
);

    sdq_pkg::state_t state_reg, state_next;

    logic [sdq_pkg::AW-1:0]    head_reg, head_next;
    logic [sdq_pkg::CW-1:0]    count_reg, count_next;
    logic [sdq_pkg::CW-1:0]    pos_reg, pos_next;
    logic [sdq_pkg::CW-1:0]    rd_idx;

    logic                      act_reg, act_next;
    logic [sdq_pkg::DUE_W-1:0] due_reg, due_next;
    logic [sdq_pkg::TAG_W-1:0] tag_reg, tag_next;
    logic [sdq_pkg::DUE_W-1:0] now_reg, now_next;

    sdq_pkg::ev_t              ev_reg, ev_next;
    logic [sdq_pkg::TAG_W-1:0] ftag_reg, ftag_next;
    logic [sdq_pkg::DUE_W-1:0] fdue_reg, fdue_next;

    // shared compare unit
    logic [sdq_pkg::DUE_W-1:0] cmp_lo, cmp_hi;
    logic                      lt;

    logic full, empty;

    assign full  = (count_reg == sdq_pkg::CW'(sdq_pkg::DEPTH));
    assign empty = (count_reg == '0);

    always_comb begin
        if (state_reg == sdq_pkg::ST_TCMP) begin
            cmp_lo = rd_data.due;
            cmp_hi = now_reg;
        end else begin
            cmp_lo = due_reg;
            cmp_hi = rd_data.due;
        end
    end

    assign lt = (cmp_lo < cmp_hi);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sdq_pkg::ST_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg  <= pos_next;
        act_reg  <= act_next;
        due_reg  <= due_next;
        tag_reg  <= tag_next;
        now_reg  <= now_next;
        ev_reg   <= ev_next;
        ftag_reg <= ftag_next;
        fdue_reg <= fdue_next;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sdq_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = sdq_pkg::ST_START;
                end
            end
            sdq_pkg::ST_START: begin
                if (act_reg == sdq_pkg::ACT_TICK) begin
                    state_next = empty ? sdq_pkg::ST_FINISH : sdq_pkg::ST_TCMP;
                end else if (full) begin
                    state_next = sdq_pkg::ST_FINISH;
                end else if (empty) begin
                    state_next = sdq_pkg::ST_PLACE;
                end else begin
                    state_next = sdq_pkg::ST_ICMP;
                end
            end
            sdq_pkg::ST_ICMP: begin
                if (lt && (pos_reg != sdq_pkg::CW'(1))) begin
                    state_next = sdq_pkg::ST_ICMP;
                end else begin
                    state_next = sdq_pkg::ST_PLACE;
                end
            end
            sdq_pkg::ST_PLACE: state_next = sdq_pkg::ST_FINISH;
            sdq_pkg::ST_TCMP:  state_next = sdq_pkg::ST_FINISH;
            sdq_pkg::ST_FINISH: begin
                if (res_ready) begin
                    state_next = sdq_pkg::ST_IDLE;
                end
            end
            default: state_next = sdq_pkg::ST_IDLE;
        endcase
    end

    // datapath and store control
    always_comb begin
        pos_next   = pos_reg;
        head_next  = head_reg;
        count_next = count_reg;
        act_next   = act_reg;
        due_next   = due_reg;
        tag_next   = tag_reg;
        now_next   = now_reg;
        ev_next    = ev_reg;
        ftag_next  = ftag_reg;
        fdue_next  = fdue_reg;
        rd_idx     = '0;

        st_req.we    = 1'b0;
        st_req.waddr = sdq_pkg::wrap_addr(head_reg, pos_reg);
        st_req.wdata = rd_data;

        unique case (state_reg)
            sdq_pkg::ST_IDLE: begin
                if (s_valid) begin
                    act_next = s_action;
                    due_next = s_due_time;
                    tag_next = s_job_tag;
                    now_next = s_now_time;
                end
            end
            sdq_pkg::ST_START: begin
                ftag_next = '0;
                fdue_next = '0;
                if (act_reg == sdq_pkg::ACT_TICK) begin
                    ev_next = sdq_pkg::EV_NONE;
                end else begin
                    // fetch the tail entry; walk back from there
                    rd_idx   = count_reg - sdq_pkg::CW'(1);
                    pos_next = count_reg;
                    ev_next  = full ? sdq_pkg::EV_DROP : sdq_pkg::EV_INSERT;
                end
            end
            sdq_pkg::ST_ICMP: begin
                rd_idx = pos_reg - sdq_pkg::CW'(2);
                if (lt) begin
                    // later deadline moves up one slot
                    st_req.we = 1'b1;
                    pos_next  = pos_reg - sdq_pkg::CW'(1);
                end
            end
            sdq_pkg::ST_PLACE: begin
                st_req.we        = 1'b1;
                st_req.wdata.due = due_reg;
                st_req.wdata.tag = tag_reg;
                count_next       = count_reg + sdq_pkg::CW'(1);
            end
            sdq_pkg::ST_TCMP: begin
                if (lt) begin
                    ev_next    = sdq_pkg::EV_FIRE;
                    ftag_next  = rd_data.tag;
                    fdue_next  = rd_data.due;
                    count_next = count_reg - sdq_pkg::CW'(1);
                    if (head_reg == sdq_pkg::AW'(sdq_pkg::DEPTH - 1)) begin
                        head_next = '0;
                    end else begin
                        head_next = head_reg + sdq_pkg::AW'(1);
                    end
                end
            end
            sdq_pkg::ST_FINISH: begin
            end
            default: begin
            end
        endcase

        st_req.raddr = sdq_pkg::wrap_addr(head_reg, rd_idx);
    end

    assign s_ready   = (state_reg == sdq_pkg::ST_IDLE);
    assign res_valid = (state_reg == sdq_pkg::ST_FINISH);
    assign res.ev    = ev_reg;
    assign res.tag   = ftag_reg;
    assign res.due   = fdue_reg;
    assign res.occ   = sdq_pkg::OCC_W'(count_reg);

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= sdq_pkg::CW'(sdq_pkg::DEPTH))
        else $error("occupancy above depth");

    a_place_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == sdq_pkg::ST_PLACE |=> count_reg == $past(count_reg) + sdq_pkg::CW'(1))
        else $error("insert did not add an entry");

    a_fire_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sdq_pkg::ST_TCMP && lt) |=>
            (count_reg == $past(count_reg) - sdq_pkg::CW'(1)) && ev_reg == sdq_pkg::EV_FIRE)
        else $error("fire did not remove the front entry");

    a_walk_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == sdq_pkg::ST_ICMP |-> pos_reg != '0)
        else $error("walk ran past the front");

endmodule

>>> dv/sorted_deadline_queue_checker.sv
// Scoreboard for the sorted deadline queue: mirrors the job list and checks each result beat.
module sorted_deadline_queue_checker
    import sdq_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_ready,
    input  logic             s_action,
    input  logic [DUE_W-1:0] s_due_time,
    input  logic [TAG_W-1:0] s_job_tag,
    input  logic [DUE_W-1:0] s_now_time,
    input  logic             m_valid,
    input  logic             m_ready,
    input  logic [1:0]       m_event_res,
    input  logic [TAG_W-1:0] m_fired_tag,
    input  logic [DUE_W-1:0] m_fired_due,
    input  logic [OCC_W-1:0] m_occupancy,
    output int               fail_count,
    output int               outstanding
);

    entry_t  job_list[$];       // pending jobs, front = earliest deadline
    result_t outcome_fifo[$];   // predicted result beats, oldest first
    result_t got;
    result_t want;
    int      errs;

    // Apply one input beat to the job list and return the result it produces.
    function automatic result_t apply_beat(input logic             act,
                                           input logic [DUE_W-1:0] due,
                                           input logic [TAG_W-1:0] tag,
                                           input logic [DUE_W-1:0] now);
        result_t r;
        entry_t  job;
        int      pos;
        r = '0;
        r.ev = EV_NONE;
        if (act == ACT_INSERT) begin
            if (job_list.size() >= DEPTH) begin
                r.ev = EV_DROP;
            end else begin
                // first job with a strictly later deadline; ties stay in arrival order
                pos = job_list.size();
                for (int i = 0; i < job_list.size(); i++) begin
                    if (pos == job_list.size() && due < job_list[i].due) begin
                        pos = i;
                    end
                end
                job.due = due;
                job.tag = tag;
                job_list.insert(pos, job);
                r.ev = EV_INSERT;
            end
        end else if (job_list.size() > 0 && job_list[0].due < now) begin
            r.ev  = EV_FIRE;
            r.tag = job_list[0].tag;
            r.due = job_list[0].due;
            void'(job_list.pop_front());
        end
        r.occ = OCC_W'(job_list.size());
        return r;
    endfunction

    function automatic int count_mismatches(input result_t exp_r, input result_t act_r);
        int n;
        n = 0;
        if (act_r.ev !== exp_r.ev) begin
            $error("event_res: expected %0d, got %0d", exp_r.ev, act_r.ev);
            n++;
        end
        if (act_r.tag !== exp_r.tag) begin
            $error("fired_tag: expected %0d, got %0d", exp_r.tag, act_r.tag);
            n++;
        end
        if (act_r.due !== exp_r.due) begin
            $error("fired_due: expected 0x%08h, got 0x%08h", exp_r.due, act_r.due);
            n++;
        end
        if (act_r.occ !== exp_r.occ) begin
            $error("occupancy: expected %0d, got %0d", exp_r.occ, act_r.occ);
            n++;
        end
        return n;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            job_list.delete();
            outcome_fifo.delete();
            fail_count  <= 0;
            outstanding <= 0;
        end else begin
            errs = 0;
            if (m_valid && m_ready) begin
                got.ev  = ev_t'(m_event_res);
                got.tag = m_fired_tag;
                got.due = m_fired_due;
                got.occ = m_occupancy;
                if (outcome_fifo.size() == 0) begin
                    $error("result beat with no pending prediction: event_res %0d", got.ev);
                    errs++;
                end else begin
                    want = outcome_fifo.pop_front();
                    errs += count_mismatches(want, got);
                end
            end
            if (s_valid && s_ready) begin
                outcome_fifo.push_back(apply_beat(s_action, s_due_time, s_job_tag, s_now_time));
            end
            fail_count  <= fail_count + errs;
            outstanding <= outcome_fifo.size();
        end
    end

endmodule

>>> dv/sorted_deadline_queue_top_test.sv
// Testbench top for the sorted deadline queue: clock, reset, stimulus and verdict.
module sorted_deadline_queue_top_test;

    logic                      aclk;
    logic                      aresetn     = 1'b0;
    logic                      s_valid     = 1'b0;
    logic                      s_ready;
    logic                      s_action    = sdq_pkg::ACT_INSERT;
    logic [sdq_pkg::DUE_W-1:0] s_due_time  = '0;
    logic [sdq_pkg::TAG_W-1:0] s_job_tag   = '0;
    logic [sdq_pkg::DUE_W-1:0] s_now_time  = '0;
    logic                      m_valid;
    logic                      m_ready     = 1'b0;
    logic [1:0]                m_event_res;
    logic [sdq_pkg::TAG_W-1:0] m_fired_tag;
    logic [sdq_pkg::DUE_W-1:0] m_fired_due;
    logic [sdq_pkg::OCC_W-1:0] m_occupancy;

    int fail_count;
    int outstanding;

    // Percent of cycles each side spends idle; changed per phase.
    int tx_idle_pct = 33;
    int rx_idle_pct = 50;

    sorted_deadline_queue_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_due_time  (s_due_time),
        .s_job_tag   (s_job_tag),
        .s_now_time  (s_now_time),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_event_res (m_event_res),
        .m_fired_tag (m_fired_tag),
        .m_fired_due (m_fired_due),
        .m_occupancy (m_occupancy)
    );

    sorted_deadline_queue_checker chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_due_time  (s_due_time),
        .s_job_tag   (s_job_tag),
        .s_now_time  (s_now_time),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_event_res (m_event_res),
        .m_fired_tag (m_fired_tag),
        .m_fired_due (m_fired_due),
        .m_occupancy (m_occupancy),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Receiver back-pressure: a fresh coin per cycle, driven on the falling edge so the
    // rising edge sees a settled m_ready.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Hard stop. Slowest legal run is ~1550 beats, each at worst a full insert walk plus
    // a stalled result; this is roughly ten times that.
    initial begin
        #5000000;
        $display("== FAIL ==");
        $finish;
    end

    // One input beat. Optional idle cycles first (valid low), then the payload goes out
    // on a falling edge and stays put until a rising edge sees s_ready. s_ready is
    // sampled in the edge's active region, i.e. before the block's own updates land.
    task automatic send_beat(input logic                      act,
                             input logic [sdq_pkg::DUE_W-1:0] due,
                             input logic [sdq_pkg::TAG_W-1:0] tag,
                             input logic [sdq_pkg::DUE_W-1:0] now);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid    <= 1'b1;
        s_action   <= act;
        s_due_time <= due;
        s_job_tag  <= tag;
        s_now_time <= now;
        do @(posedge aclk); while (!s_ready);
    endtask

    initial begin
        logic [sdq_pkg::DUE_W-1:0] base_time;   // moving notion of "now" for the random part
        logic [sdq_pkg::DUE_W-1:0] due;
        logic [sdq_pkg::DUE_W-1:0] now;
        logic                      act;
        int                        insert_pct;
        int                        r;

        base_time  = $urandom;
        insert_pct = 50;

        // Reset: held low, then released on a falling edge.
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // ---- directed part ----
        // ticks on an empty store, at both ends of the time range
        send_beat(sdq_pkg::ACT_TICK, $urandom, sdq_pkg::TAG_W'($urandom), 32'h0000_0000);
        send_beat(sdq_pkg::ACT_TICK, $urandom, sdq_pkg::TAG_W'($urandom), 32'hFFFF_FFFF);
        // equal deadlines must keep arrival order; extremes of deadline and tag
        send_beat(sdq_pkg::ACT_INSERT, 32'd100, 8'd0, $urandom);
        send_beat(sdq_pkg::ACT_INSERT, 32'd100, 8'd255, $urandom);
        send_beat(sdq_pkg::ACT_INSERT, 32'h0000_0000, 8'd1, $urandom);
        send_beat(sdq_pkg::ACT_INSERT, 32'hFFFF_FFFF, 8'd2, $urandom);
        // deadline equal to now does not fire; one past it does
        send_beat(sdq_pkg::ACT_TICK, $urandom, sdq_pkg::TAG_W'($urandom), 32'd0);
        send_beat(sdq_pkg::ACT_TICK, $urandom, sdq_pkg::TAG_W'($urandom), 32'd1);
        send_beat(sdq_pkg::ACT_TICK, $urandom, sdq_pkg::TAG_W'($urandom), 32'd100);
        send_beat(sdq_pkg::ACT_TICK, $urandom, sdq_pkg::TAG_W'($urandom), 32'd101);
        send_beat(sdq_pkg::ACT_TICK, $urandom, sdq_pkg::TAG_W'($urandom), 32'd101);
        // max deadline never fires, even at max time
        send_beat(sdq_pkg::ACT_TICK, $urandom, sdq_pkg::TAG_W'($urandom), 32'hFFFF_FFFF);
        // fill to DEPTH, then one more is dropped
        for (int i = 0; i < sdq_pkg::DEPTH; i++) begin
            send_beat(sdq_pkg::ACT_INSERT, $urandom, sdq_pkg::TAG_W'($urandom), $urandom);
        end
        send_beat(sdq_pkg::ACT_TICK, $urandom, sdq_pkg::TAG_W'($urandom), 32'hFFFF_FFFF);

        // ---- random part, three idling phases ----
        // Segments of 40 beats pick a random insert bias so the store drains, sits half
        // full or saturates by chance. Deadlines cluster just past base_time so ticks
        // that creep base_time forward keep firing jobs; a few full-range values
        // cover every bit and clog the store until a max-time tick drains them.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin tx_idle_pct = 33; rx_idle_pct = 50; end
                1: begin tx_idle_pct = 50; rx_idle_pct = 33; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            for (int n = 0; n < 500; n++) begin
                if (n % 40 == 0) begin
                    case ($urandom_range(0, 3))
                        0: insert_pct = 20;
                        1: insert_pct = 45;
                        2: insert_pct = 70;
                        default: insert_pct = 90;
                    endcase
                    if ($urandom_range(0, 4) == 0) begin
                        base_time = $urandom;
                    end
                end
                act = ($urandom_range(0, 99) < insert_pct) ? sdq_pkg::ACT_INSERT
                                                            : sdq_pkg::ACT_TICK;
                due = $urandom;
                now = $urandom;
                r   = $urandom_range(0, 99);
                if (act == sdq_pkg::ACT_INSERT) begin
                    if (r < 70) begin
                        due = base_time + $urandom_range(0, 48);
                    end else if (r < 85) begin
                        due = base_time - $urandom_range(0, 8);
                    end
                    // else: full-range deadline already in due
                end else begin
                    if (r < 85) begin
                        base_time = base_time + $urandom_range(0, 4);
                        now = base_time;
                    end else if (r >= 93) begin
                        now = 32'hFFFF_FFFF;
                    end
                end
                send_beat(act, due, sdq_pkg::TAG_W'($urandom), now);
            end
        end

        @(negedge aclk);
        s_valid <= 1'b0;

        // Drain: wait for every predicted beat, then a tail to catch strays.
        while (outstanding != 0) @(negedge aclk);
        repeat (64) @(negedge aclk);

        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/core/sdq_pkg.sv
rtl/core/sdq_store.sv
rtl/core/sdq_seq.sv
rtl/core/sorted_deadline_queue_top.sv
dv/sorted_deadline_queue_checker.sv
dv/sorted_deadline_queue_top_test.sv
